[hw/rtl/hfr_pkg.sv]
// Shared types and constants for the HDLC frame receiver.
package hfr_pkg;

  localparam logic [7:0]  FLAG_OCTET    = 8'h7E;
  localparam logic [7:0]  LEN_HIGH_MASK = 8'h07;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;
  localparam int          MIN_LENGTH    = 3;
  localparam int          CLOSE_EXTRA   = 2;
  localparam int          QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_CONSUME = 2'd2,
    ACT_READ    = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_DONE    = 3'd2,
    ST_DISCARD = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_DROP    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BODY  = 2'd1,
    PH_CLOSE = 2'd2
  } phase_t;

  typedef struct packed {
    act_t        kind;
    logic [7:0]  data;
    logic [10:0] idx;
    logic        idx_ok;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        ready;
    logic [11:0] length;
    logic        rd;
  } res_t;

endpackage

[hw/rtl/hdlc_frame_receiver.sv]
// Results pass through the input register, the item queue and the output register.
// Throughput: one item per cycle unless stalled. Frame store: one write, one read port.
// Each item gives exactly one result item.
// Reset (rst, synchronous, active high) clears the receiver to idle, no frame held,
// timeout limit 100; the frame store keeps its contents and needs no clearing pass.
module hdlc_frame_receiver import hfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [10:0] read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        frame_ready,
  output logic [11:0] held_length,
  output logic [7:0]  read_data
);

  logic  f_valid;
  item_t f_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  hfr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .data_byte  (data_byte),
    .read_index (read_index),
    .q_valid    (f_valid),
    .q_item     (f_item),
    .q_full     (q_full)
  );

  hfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_item  (f_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  hfr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .frame_ready  (frame_ready),
    .held_length  (held_length),
    .read_data    (read_data)
  );

endmodule

[hw/rtl/hfr_front.sv]
// Input stage: accepts items and classifies the action.
module hfr_front import hfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [10:0] read_index,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_full
);

  logic  fv;
  item_t f_item;
  item_t f_item_next;

  assign in_stall = fv && q_full;
  assign q_valid  = fv;
  assign q_item   = f_item;

  always_comb begin
    f_item_next.kind   = act_t'(action);
    f_item_next.data   = data_byte;
    f_item_next.idx    = read_index;
    f_item_next.idx_ok = (int'(read_index) < BUFFER_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!in_stall) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      f_item <= f_item_next;
    end
  end

endmodule

[hw/rtl/hfr_queue.sv]
// Short item queue between the classify stage and the execute stage.
module hfr_queue import hfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push_ok;
  logic            pop_ok;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign push_ok    = push_valid && !full;
  assign pop_ok     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[hw/rtl/hfr_back.sv]
// Execute stage: frame state machine, frame store and output register.
module hfr_back import hfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        frame_ready,
  output logic [11:0] held_length,
  output logic [7:0]  read_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [7:0]    store [BUFFER_DEPTH];
  logic [7:0]    mem_q;

  phase_t        phase, phase_next;
  logic [11:0]   wp, wp_next;
  logic [11:0]   el, el_next;
  logic [15:0]   tick, tick_next;
  logic          armed, armed_next;
  logic          ready, ready_next;
  logic [2:0]    len_hi, len_hi_next;
  logic [7:0]    len_lo, len_lo_next;
  logic [15:0]   timeout_limit;

  logic          ov;
  res_t          res, res_next;
  logic          adv;
  logic          due;
  logic          we;
  logic [AW-1:0] waddr;
  logic          rd_en;
  phase_t        eff_phase;
  logic [11:0]   len;
  logic          len_bad;
  logic [11:0]   el_cur;
  logic [15:0]   tick_sat;
  status_t       st;

  assign adv   = !ov || !out_stall;
  assign q_pop = q_valid && adv;
  assign due   = armed && (tick > timeout_limit);
  assign len   = {1'b0, len_hi, len_lo};
  assign len_bad = (len < 12'(MIN_LENGTH)) ||
                   ((13'(len) + 13'(CLOSE_EXTRA)) > 13'(BUFFER_DEPTH));
  assign eff_phase = due ? PH_IDLE : phase;
  assign tick_sat  = (tick == TICK_MAX) ? tick : tick + 16'd1;

  always_comb begin
    phase_next  = phase;
    wp_next     = wp;
    el_next     = el;
    tick_next   = tick;
    armed_next  = armed;
    ready_next  = ready;
    len_hi_next = len_hi;
    len_lo_next = len_lo;
    we          = 1'b0;
    waddr       = AW'(wp);
    rd_en       = 1'b0;
    el_cur      = el;
    st          = ST_NONE;
    unique case (q_item.kind)
      ACT_BYTE: begin
        if (due) begin
          phase_next = PH_IDLE;
          wp_next    = '0;
          el_next    = '0;
          tick_next  = '0;
          armed_next = 1'b0;
        end
        unique case (eff_phase)
          PH_IDLE: begin
            if (ready) begin
              st = ST_DROP;
            end else if (q_item.data == FLAG_OCTET) begin
              we         = 1'b1;
              waddr      = '0;
              wp_next    = 12'd1;
              el_next    = '0;
              phase_next = PH_BODY;
              armed_next = 1'b1;
              tick_next  = '0;
              st         = ST_TAKEN;
            end
          end
          PH_BODY: begin
            if (wp == 12'd3 && len_bad) begin
              phase_next = PH_IDLE;
              wp_next    = '0;
              el_next    = '0;
              tick_next  = '0;
              armed_next = 1'b0;
              st         = ST_DISCARD;
            end else begin
              if (wp == 12'd3) begin
                el_cur = len;
              end
              el_next = el_cur;
              we      = 1'b1;
              wp_next = wp + 12'd1;
              if (wp == 12'd1) begin
                len_hi_next = 3'(q_item.data & LEN_HIGH_MASK);
              end
              if (wp == 12'd2) begin
                len_lo_next = q_item.data;
              end
              if (wp_next >= 12'd4 && wp_next == el_cur + 12'd1) begin
                phase_next = PH_CLOSE;
              end
              st = ST_TAKEN;
            end
          end
          PH_CLOSE: begin
            if (q_item.data != FLAG_OCTET) begin
              phase_next = PH_IDLE;
              wp_next    = '0;
              el_next    = '0;
              tick_next  = '0;
              armed_next = 1'b0;
              st         = ST_DISCARD;
            end else begin
              we         = 1'b1;
              wp_next    = wp + 12'd1;
              el_next    = el + 12'(CLOSE_EXTRA);
              ready_next = 1'b1;
              armed_next = 1'b0;
              phase_next = PH_IDLE;
              st         = ST_DONE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            wp_next    = '0;
            el_next    = '0;
            tick_next  = '0;
            armed_next = 1'b0;
          end
        endcase
      end
      ACT_TICK: begin
        tick_next = tick_sat;
        if (armed && (tick_sat > timeout_limit)) begin
          phase_next = PH_IDLE;
          wp_next    = '0;
          el_next    = '0;
          tick_next  = '0;
          armed_next = 1'b0;
          st         = ST_TIMEOUT;
        end
      end
      ACT_CONSUME: begin
        ready_next = 1'b0;
        phase_next = PH_IDLE;
        wp_next    = '0;
        el_next    = '0;
        tick_next  = '0;
        armed_next = 1'b0;
      end
      ACT_READ: begin
        rd_en = q_item.idx_ok;
      end
      default: begin
        st = ST_NONE;
      end
    endcase
    res_next.status = st;
    res_next.ready  = ready_next;
    res_next.length = ready_next ? el_next : '0;
    res_next.rd     = rd_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wp            <= '0;
      el            <= '0;
      tick          <= '0;
      armed         <= 1'b0;
      ready         <= 1'b0;
      ov            <= 1'b0;
      timeout_limit <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        timeout_limit <= cfg_wr_data;
      end
      if (adv) begin
        ov <= q_valid;
      end
      if (q_pop) begin
        phase <= phase_next;
        wp    <= wp_next;
        el    <= el_next;
        tick  <= tick_next;
        armed <= armed_next;
        ready <= ready_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res    <= res_next;
      len_hi <= len_hi_next;
      len_lo <= len_lo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && we) begin
      store[waddr] <= q_item.data;
    end
    if (q_pop && rd_en) begin
      mem_q <= store[AW'(q_item.idx)];
    end
  end

  assign out_valid   = ov;
  assign status      = res.status;
  assign frame_ready = res.ready;
  assign held_length = res.length;
  assign read_data   = res.rd ? mem_q : '0;

  a_held_length: assert property (@(posedge clk) disable iff (rst)
    ov && res.ready |-> res.length >= 12'(MIN_LENGTH + CLOSE_EXTRA))
    else $error("held frame shorter than minimum");

  a_no_rx_while_held: assert property (@(posedge clk) disable iff (rst)
    ready |-> phase == PH_IDLE)
    else $error("frame in progress while a frame is held");

  a_done_sets_ready: assert property (@(posedge clk) disable iff (rst)
    ov && res.status == ST_DONE |-> res.ready)
    else $error("completed frame not marked ready");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ov && out_stall |=> ov && $stable(res))
    else $error("stalled result changed");

endmodule

[sim/hdlc_frame_receiver_checker.sv]
// Checker for the HDLC frame receiver: tracks each accepted item, predicts its report, compares.
module hdlc_frame_receiver_checker import hfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [10:0] read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic        frame_ready,
  input  logic [11:0] held_length,
  input  logic [7:0]  read_data,
  output int          mismatches,
  output int          outstanding,
  output int          reports_checked,
  output int          stored_span
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t     status;
    logic        ready;
    logic [11:0] length;
    logic [7:0]  rdata;
  } rx_report_t;

  rx_report_t  pending_reports[$];
  phase_t      rx_phase = PH_IDLE;
  logic [11:0] wr_pos = '0;
  logic [11:0] frame_len = '0;
  logic [15:0] tick_cnt = '0;
  logic [15:0] timeout_limit = TIMEOUT_RESET;
  logic        timer_armed = 1'b0;
  logic        frame_held = 1'b0;
  logic [7:0]  frame_mem [BUFFER_DEPTH];
  int          span = 0;
  int          errors = 0;
  int          checked = 0;

  function automatic void abandon_frame();
    rx_phase = PH_IDLE;
    wr_pos = '0;
    frame_len = '0;
    tick_cnt = '0;
    timer_armed = 1'b0;
  endfunction

  function automatic void store_octet(logic [7:0] b);
    if (wr_pos < BUFFER_DEPTH) begin
      frame_mem[wr_pos] = b;
      wr_pos = wr_pos + 12'd1;
      if (int'(wr_pos) > span) span = int'(wr_pos);
    end
  endfunction

  function automatic status_t receive_octet(logic [7:0] b);
    int      hdr_len;
    status_t st;
    st = ST_NONE;
    // apply a timeout that became due before this byte
    if (timer_armed && tick_cnt > timeout_limit) abandon_frame();
    case (rx_phase)
      PH_IDLE: begin
        if (frame_held) begin
          st = ST_DROP;
        end else if (b == FLAG_OCTET) begin
          wr_pos = '0;
          frame_len = '0;
          store_octet(b);
          rx_phase = PH_BODY;
          timer_armed = 1'b1;
          tick_cnt = '0;
          st = ST_TAKEN;
        end
      end
      PH_BODY: begin
        st = ST_TAKEN;
        if (wr_pos == 12'd3) begin
          hdr_len = (int'(frame_mem[1] & LEN_HIGH_MASK) << 8) | int'(frame_mem[2]);
          if (hdr_len < MIN_LENGTH || hdr_len + CLOSE_EXTRA > BUFFER_DEPTH) begin
            abandon_frame();
            st = ST_DISCARD;
          end else begin
            frame_len = hdr_len[11:0];
          end
        end
        if (st == ST_TAKEN) begin
          store_octet(b);
          if (wr_pos >= 12'd4 && wr_pos == frame_len + 12'd1) rx_phase = PH_CLOSE;
        end
      end
      PH_CLOSE: begin
        if (b != FLAG_OCTET) begin
          abandon_frame();
          st = ST_DISCARD;
        end else begin
          store_octet(b);
          frame_len = frame_len + 12'(CLOSE_EXTRA);
          frame_held = 1'b1;
          timer_armed = 1'b0;
          rx_phase = PH_IDLE;
          st = ST_DONE;
        end
      end
      default: abandon_frame();
    endcase
    return st;
  endfunction

  function automatic rx_report_t step_receiver(act_t act, logic [7:0] b, logic [10:0] idx);
    rx_report_t r;
    r.status = ST_NONE;
    r.rdata = '0;
    case (act)
      ACT_BYTE: r.status = receive_octet(b);
      ACT_TICK: begin
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 16'd1;
        if (timer_armed && tick_cnt > timeout_limit) begin
          abandon_frame();
          r.status = ST_TIMEOUT;
        end
      end
      ACT_CONSUME: begin
        frame_held = 1'b0;
        abandon_frame();
      end
      default: if (int'(idx) < BUFFER_DEPTH) r.rdata = frame_mem[idx];
    endcase
    r.ready = frame_held;
    r.length = frame_held ? frame_len : 12'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    rx_report_t want;
    if (rst) begin
      abandon_frame();
      frame_held = 1'b0;
      timeout_limit = TIMEOUT_RESET;
      pending_reports.delete();
    end else begin
      if (cfg_wr_en) timeout_limit = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected report status %0d ready %0b length %0d data %02h",
                     $realtime, status, frame_ready, held_length, read_data);
        end else begin
          want = pending_reports.pop_front();
          checked++;
          if (status !== want.status || frame_ready !== want.ready ||
              held_length !== want.length || read_data !== want.rdata) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: report %0d expected status %0d ready %0b length %0d data %02h",
                       $realtime, checked, want.status, want.ready, want.length, want.rdata);
              $display("%0t: report %0d got status %0d ready %0b length %0d data %02h",
                       $realtime, checked, status, frame_ready, held_length, read_data);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        pending_reports.push_back(step_receiver(act_t'(action), data_byte, read_index));
    end
    mismatches <= errors;
    outstanding <= pending_reports.size();
    reports_checked <= checked;
    stored_span <= span;
  end

endmodule

[sim/hdlc_frame_receiver_tb.sv]
// Testbench top for the HDLC frame receiver: clock, reset, stimulus and verdict.
module hdlc_frame_receiver_tb import hfr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_DEPTH    = 2048;
  localparam int MAX_LEN      = BUF_DEPTH - CLOSE_EXTRA;
  localparam int BIG_LEN      = 400;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_BYTE;
  logic [7:0]  data_byte = '0;
  logic [10:0] read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        frame_ready;
  logic [11:0] held_length;
  logic [7:0]  read_data;

  int mismatches;
  int outstanding;
  int reports_checked;
  int stored_span;
  int items_sent = 0;
  int limit_writes = 0;
  int cycles = 0;
  bit steady = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  hdlc_frame_receiver #(.BUFFER_DEPTH(BUF_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .data_byte(data_byte), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .frame_ready(frame_ready),
    .held_length(held_length), .read_data(read_data)
  );

  hdlc_frame_receiver_checker #(.BUFFER_DEPTH(BUF_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .data_byte(data_byte), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .frame_ready(frame_ready),
    .held_length(held_length), .read_data(read_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .reports_checked(reports_checked), .stored_span(stored_span)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hdlc_frame_receiver test failed");
      $finish;
    end
  end

  // hold off the output for a long stretch on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_item(act_t act, logic [7:0] b, logic [10:0] idx);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    data_byte <= b;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_octet(logic [7:0] b);
    send_item(ACT_BYTE, b, 11'($urandom));
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, 8'($urandom), 11'($urandom));
  endtask

  task automatic send_consume();
    send_item(ACT_CONSUME, 8'($urandom), 11'($urandom));
  endtask

  function automatic logic [10:0] pick_index();
    return 11'($urandom_range(stored_span - 1, 0));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_writes++;
  endtask

  task automatic send_frame(int len, bit close_ok, int tick_pct);
    int         body;
    logic [7:0] fmt;
    logic [7:0] last;
    body = (len < MIN_LENGTH || len > MAX_LEN) ? 1 : len - 2;
    fmt = 8'($urandom);
    send_octet(FLAG_OCTET);
    send_octet({fmt[7:3], len[10:8]});
    send_octet(len[7:0]);
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      send_octet(8'($urandom));
    end
    if (len >= MIN_LENGTH && len <= MAX_LEN) begin
      last = 8'($urandom);
      if (close_ok || last == FLAG_OCTET) last = close_ok ? FLAG_OCTET : 8'h00;
      send_octet(last);
    end
  endtask

  task automatic serve_held();
    repeat ($urandom_range(3)) send_item(ACT_READ, 8'($urandom), pick_index());
    if ($urandom_range(99) < 20) send_octet(8'($urandom));
    if ($urandom_range(99) < 85) send_consume();
  endtask

  task automatic random_burst();
    int   pick;
    int   n;
    act_t act;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_frame($urandom_range(40, MIN_LENGTH), $urandom_range(99) < 90, 8);
      serve_held();
    end else if (pick < 70) begin
      n = $urandom_range(3);
      send_frame(n == 3 ? MAX_LEN + 1 : n, 1'b1, 0);
    end else if (pick < 80) begin
      send_octet(FLAG_OCTET);
      repeat ($urandom_range(5)) send_octet(8'($urandom));
      send_consume();
    end else if (pick < 90) begin
      repeat ($urandom_range(4, 1)) send_tick();
    end else begin
      act = act_t'($urandom_range(3));
      if (act == ACT_READ && stored_span == 0) act = ACT_TICK;
      send_item(act, 8'($urandom), act == ACT_READ ? pick_index() : 11'($urandom));
    end
  endtask

  initial begin
    int          goal;
    logic [15:0] lim;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_octet(8'h00);
    send_octet(8'hFF);
    send_frame(2, 1'b1, 0);
    send_frame(MAX_LEN + 1, 1'b1, 0);
    send_frame(MIN_LENGTH, 1'b1, 0);
    send_octet(FLAG_OCTET);
    send_tick();
    send_item(ACT_READ, 8'($urandom), 11'd4);
    send_item(ACT_READ, 8'($urandom), 11'd0);
    send_consume();
    send_frame(MIN_LENGTH, 1'b0, 0);

    drain();
    write_limit(16'd0);
    send_octet(FLAG_OCTET);
    send_tick();

    // lower the limit under a running frame, then let a byte see it
    drain();
    write_limit(16'hFFFF);
    send_octet(FLAG_OCTET);
    repeat (5) send_tick();
    drain();
    write_limit(16'd2);
    send_octet(8'h55);
    send_octet(FLAG_OCTET);
    repeat (4) send_tick();
    drain();
    write_limit(16'hFFFF);
    send_octet(FLAG_OCTET);
    repeat (4) send_tick();
    drain();
    write_limit(16'd1);
    send_octet(FLAG_OCTET);
    send_consume();

    // hold a frame open under the largest limit
    drain();
    write_limit(TICK_MAX);
    steady = 1'b1;
    send_octet(FLAG_OCTET);
    repeat (20) send_tick();
    steady = 1'b0;
    drain();
    write_limit(TICK_MAX - 16'd1);
    send_tick();

    // long frame, with the output held off
    drain();
    write_limit(TICK_MAX);
    hold_req++;
    send_frame(BIG_LEN, 1'b1, 0);
    send_item(ACT_READ, 8'($urandom), 11'(BIG_LEN + 1));
    send_item(ACT_READ, 8'($urandom), 11'(BIG_LEN / 2));
    serve_held();
    send_consume();

    // header at the buffer limit, then abort it
    send_octet(FLAG_OCTET);
    send_octet(8'(MAX_LEN >> 8));
    send_octet(8'(MAX_LEN));
    send_octet(8'h11);
    send_consume();

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: lim = 16'd3;
        1: lim = 16'd20;
        2: lim = 16'd0;
        3: lim = TIMEOUT_RESET;
        4: lim = TICK_MAX;
        default: lim = 16'($urandom);
      endcase
      write_limit(lim);
      steady = (p == 3);
      goal = items_sent + RANDOM_ITEMS / 6;
      while (items_sent < goal) random_burst();
    end
    steady = 1'b0;
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d items and %0d checked reports across %0d timeout settings.",
             items_sent, reports_checked, limit_writes);
    $display("Frames up to %0d bytes, limit headers, bad closes, timeouts, drops and reads.",
             BIG_LEN + CLOSE_EXTRA);
    if (mismatches == 0) begin
      $display("hdlc_frame_receiver test passed");
    end else begin
      $display("hdlc_frame_receiver test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/hfr_pkg.sv
hw/rtl/hfr_front.sv
hw/rtl/hfr_queue.sv
hw/rtl/hfr_back.sv
hw/rtl/hdlc_frame_receiver.sv
sim/hdlc_frame_receiver_checker.sv
sim/hdlc_frame_receiver_tb.sv
